// ----- sv/vector3_arithmetic_unit_defines.svh -----
// Assertion macros for the vector3 arithmetic unit checker.
// No dependencies; include by bare file name.
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define VAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/vau_pkg.sv -----
// Shared types, codes and helpers for the vector3 arithmetic unit.
// No dependencies.
package vau_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_COMP_BITS = 32;
   localparam int OUT_W         = 49;
   localparam int FUNC_W        = 3;
   localparam int STATUS_W      = 2;
   // wide enough for any full-precision sum at the largest component width
   localparam int WIDE_W        = 66;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DOT   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CROSS = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UNIT  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_VEC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OP   = 2'd2;

   // control and finished results that ride along the cell chain
   typedef struct packed {
      logic                       valid;
      logic [FUNC_W-1:0]          func;
      logic [2:0]                 neg;
      logic signed [OUT_W-1:0]    res_x;
      logic signed [OUT_W-1:0]    res_y;
      logic signed [OUT_W-1:0]    res_z;
      logic signed [OUT_W-1:0]    scalar;
      logic [STATUS_W-1:0]        status;
   } vau_side_type;

   // saturate a wide signed value to the result field range
   function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[OUT_W-1:0];
      end else if (v < lo) begin
         return lo[OUT_W-1:0];
      end
      return v[OUT_W-1:0];
   endfunction

endpackage

// ----- sv/vau_sqrt_cell.sv -----
// One digit step of the floor square root, two radicand bits per cell.
// Depends on vau_pkg.
module vau_sqrt_cell import vau_pkg::*; #(
   parameter int ROOT_W = DEF_COMP_BITS,
   parameter int PASS_W = 3 * DEF_COMP_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  vau_side_type          side_in,
   input  logic [2*ROOT_W-1:0]   rad_in,
   input  logic [ROOT_W:0]       rem_in,
   input  logic [ROOT_W-1:0]     root_in,
   input  logic [PASS_W-1:0]     pass_in,
   output vau_side_type          side_out,
   output logic [2*ROOT_W-1:0]   rad_out,
   output logic [ROOT_W:0]       rem_out,
   output logic [ROOT_W-1:0]     root_out,
   output logic [PASS_W-1:0]     pass_out
);

   logic [ROOT_W+2:0]   rem_try;
   logic [ROOT_W+2:0]   trial;
   logic [ROOT_W+2:0]   rem_diff;
   logic                take;

   vau_side_type        side_ff;
   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W:0]     rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [PASS_W-1:0]   pass_ff;

   // bring down the next two radicand bits and try the next root bit
   assign rem_try  = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
   assign trial    = {1'b0, root_in, 2'b01};
   assign take     = (rem_try >= trial);
   assign rem_diff = take ? (rem_try - trial) : rem_try;

   // hold the valid flag under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_in.valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.func   <= side_in.func;
         side_ff.neg    <= side_in.neg;
         side_ff.res_x  <= side_in.res_x;
         side_ff.res_y  <= side_in.res_y;
         side_ff.res_z  <= side_in.res_z;
         side_ff.scalar <= side_in.scalar;
         side_ff.status <= side_in.status;
         rad_ff         <= {rad_in[2*ROOT_W-3:0], 2'b00};
         rem_ff         <= rem_diff[ROOT_W:0];
         root_ff        <= {root_in[ROOT_W-2:0], take};
         pass_ff        <= pass_in;
      end
   end

   assign side_out = side_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign pass_out = pass_ff;

endmodule

// ----- sv/vau_div_cell.sv -----
// One quotient bit of the three unit-vector divisions, restoring form.
// Depends on vau_pkg.
module vau_div_cell import vau_pkg::*; #(
   parameter int MAG_W = DEF_COMP_BITS,
   parameter int Q_W   = DEF_FRAC_BITS + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  vau_side_type             side_in,
   input  logic [MAG_W-1:0]         mag_in,
   input  logic [2:0][MAG_W:0]      part_in,
   input  logic [2:0][Q_W-1:0]      quo_in,
   output vau_side_type             side_out,
   output logic [MAG_W-1:0]         mag_out,
   output logic [2:0][MAG_W:0]      part_out,
   output logic [2:0][Q_W-1:0]      quo_out
);

   logic [2:0]             ge;
   logic [2:0][MAG_W:0]    diff;

   vau_side_type           side_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic [2:0][MAG_W:0]    part_ff;
   logic [2:0][Q_W-1:0]    quo_ff;

   // compare each partial remainder with the magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ge[i]   = (part_in[i] >= {1'b0, mag_in});
         diff[i] = ge[i] ? (part_in[i] - {1'b0, mag_in}) : part_in[i];
      end
   end

   // hold the valid flag under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_in.valid;
      end
   end

   // advance the payload, doubling the remainders
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.func   <= side_in.func;
         side_ff.neg    <= side_in.neg;
         side_ff.res_x  <= side_in.res_x;
         side_ff.res_y  <= side_in.res_y;
         side_ff.res_z  <= side_in.res_z;
         side_ff.scalar <= side_in.scalar;
         side_ff.status <= side_in.status;
         mag_ff         <= mag_in;
         for (int i = 0; i < 3; i++) begin
            part_ff[i] <= {diff[i][MAG_W-1:0], 1'b0};
            quo_ff[i]  <= {quo_in[i][Q_W-2:0], ge[i]};
         end
      end
   end

   assign side_out = side_ff;
   assign mag_out  = mag_ff;
   assign part_out = part_ff;
   assign quo_out  = quo_ff;

endmodule

// ----- sv/vector3_arithmetic_unit.sv -----
// Vector3 arithmetic unit: add, subtract, dot, cross, magnitude and unit vector.
// Depends on vau_pkg, vau_sqrt_cell and vau_div_cell.
//
// Takes one beat per clock while req_tready is high and returns one result beat
// per input beat, in order. Every beat passes the same pipeline: input register,
// multiplier stage, sum stage, result stage, COMP_BITS square root cells,
// FRAC_BITS+1 divider cells and the output register. A one-beat skid register
// after the output keeps the input side open while a finished result waits;
// req_tready drops only while that skid register is full.
module vector3_arithmetic_unit import vau_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int COMP_BITS = DEF_COMP_BITS,
   localparam int REQ_W = ((6 * COMP_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((4 * OUT_W + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
   input  logic [FUNC_W-1:0]    req_tuser,   // func
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // res_x, res_y, res_z, scalar
   output logic [STATUS_W-1:0]  rsp_tuser    // status
);

   localparam int C      = COMP_BITS;
   localparam int F      = FRAC_BITS;
   localparam int PROD_W = 2 * C;
   localparam int SUM_W  = 2 * C + 2;
   localparam int Q_W    = F + 1;

   logic en;

   // input register
   logic                 v0_ff;
   logic [FUNC_W-1:0]    func0_ff;
   logic signed [C-1:0]  a0_ff [3];
   logic signed [C-1:0]  b0_ff [3];

   // multiplier stage
   logic signed [C-1:0]      opa [3];
   logic signed [C-1:0]      opb [3];
   logic signed [PROD_W-1:0] prod_in [6];
   logic signed [C:0]        addsub_in [3];
   logic                     v1_ff;
   logic [FUNC_W-1:0]        func1_ff;
   logic signed [C-1:0]      a1_ff [3];
   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [C:0]        addsub1_ff [3];

   // sum stage
   logic                     v2_ff;
   logic [FUNC_W-1:0]        func2_ff;
   logic signed [C-1:0]      a2_ff [3];
   logic signed [C:0]        addsub2_ff [3];
   logic signed [SUM_W-1:0]  dot_ff;
   logic signed [SUM_W-1:0]  crs_ff [3];

   // result stage
   vau_side_type             side3_in;
   vau_side_type             side3_ff;
   logic [PROD_W-1:0]        rad3_ff;
   logic [3*C-1:0]           abs3_in;
   logic [3*C-1:0]           abs3_ff;
   logic signed [WIDE_W-1:0] dot_wide;
   logic signed [WIDE_W-1:0] crs_wide [3];
   logic signed [WIDE_W-1:0] as_wide [3];

   // cell chains
   vau_side_type             side_c [C+1];
   logic [PROD_W-1:0]        rad_c  [C+1];
   logic [C:0]               rem_c  [C+1];
   logic [C-1:0]             root_c [C+1];
   logic [3*C-1:0]           pass_c [C+1];
   vau_side_type             side_d [Q_W+1];
   logic [C-1:0]             mag_d  [Q_W+1];
   logic [2:0][C:0]          part_d [Q_W+1];
   logic [2:0][Q_W-1:0]      quo_d  [Q_W+1];

   // output register and skid
   vau_side_type             out_in;
   vau_side_type             out_ff;
   vau_side_type             skid_ff;
   logic                     skid_valid_ff;
   vau_side_type             last;
   logic [2:0]               neg_l;
   logic [2:0][Q_W-1:0]      quo_l;
   logic [C-1:0]             mag_l;

   assign en         = ~skid_valid_ff;
   assign req_tready = en;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func0_ff <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            a0_ff[i] <= req_tdata[i*C +: C];
            b0_ff[i] <= req_tdata[(i+3)*C +: C];
         end
      end
   end

   // select multiplier operands: cross uses six products, dot and magnitude three
   always_comb begin
      if (func0_ff == FUNC_CROSS) begin
         opa[0] = a0_ff[1];
         opb[0] = b0_ff[2];
         opa[1] = a0_ff[2];
         opb[1] = b0_ff[1];
         opa[2] = a0_ff[2];
         opb[2] = b0_ff[0];
      end else begin
         for (int i = 0; i < 3; i++) begin
            opa[i] = a0_ff[i];
            opb[i] = (func0_ff == FUNC_UNIT) ? a0_ff[i] : b0_ff[i];
         end
      end
      prod_in[0] = PROD_W'(opa[0]) * PROD_W'(opb[0]);
      prod_in[1] = PROD_W'(opa[1]) * PROD_W'(opb[1]);
      prod_in[2] = PROD_W'(opa[2]) * PROD_W'(opb[2]);
      prod_in[3] = PROD_W'(a0_ff[0]) * PROD_W'(b0_ff[2]);
      prod_in[4] = PROD_W'(a0_ff[0]) * PROD_W'(b0_ff[1]);
      prod_in[5] = PROD_W'(a0_ff[1]) * PROD_W'(b0_ff[0]);
      for (int i = 0; i < 3; i++) begin
         if (func0_ff == FUNC_SUB) begin
            addsub_in[i] = (C+1)'(a0_ff[i]) - (C+1)'(b0_ff[i]);
         end else begin
            addsub_in[i] = (C+1)'(a0_ff[i]) + (C+1)'(b0_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func1_ff <= func0_ff;
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]      <= a0_ff[i];
            addsub1_ff[i] <= addsub_in[i];
         end
      end
   end

   // sum products at full precision
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func2_ff  <= func1_ff;
         dot_ff    <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
         crs_ff[0] <= SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]);
         crs_ff[1] <= SUM_W'(prod_ff[2]) - SUM_W'(prod_ff[3]);
         crs_ff[2] <= SUM_W'(prod_ff[4]) - SUM_W'(prod_ff[5]);
         for (int i = 0; i < 3; i++) begin
            a2_ff[i]      <= a1_ff[i];
            addsub2_ff[i] <= addsub1_ff[i];
         end
      end
   end

   // floor shift, saturate and pick the finished results
   always_comb begin
      dot_wide = WIDE_W'(dot_ff >>> F);
      for (int i = 0; i < 3; i++) begin
         crs_wide[i] = WIDE_W'(crs_ff[i] >>> F);
         as_wide[i]  = WIDE_W'(addsub2_ff[i]);
         abs3_in[i*C +: C] = a2_ff[i][C-1] ? (~a2_ff[i] + 1'b1) : a2_ff[i];
      end
      side3_in.valid  = v2_ff;
      side3_in.func   = func2_ff;
      side3_in.neg    = {a2_ff[2][C-1], a2_ff[1][C-1], a2_ff[0][C-1]};
      side3_in.res_x  = '0;
      side3_in.res_y  = '0;
      side3_in.res_z  = '0;
      side3_in.scalar = '0;
      side3_in.status = STATUS_OK;
      case (func2_ff)
         FUNC_ADD, FUNC_SUB: begin
            side3_in.res_x = clamp_out(as_wide[0]);
            side3_in.res_y = clamp_out(as_wide[1]);
            side3_in.res_z = clamp_out(as_wide[2]);
         end
         FUNC_DOT: begin
            side3_in.scalar = clamp_out(dot_wide);
         end
         FUNC_CROSS: begin
            side3_in.res_x = clamp_out(crs_wide[0]);
            side3_in.res_y = clamp_out(crs_wide[1]);
            side3_in.res_z = clamp_out(crs_wide[2]);
         end
         FUNC_UNIT: begin
            side3_in.status = STATUS_OK;
         end
         default: begin
            side3_in.status = STATUS_BAD_OP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff.valid <= 1'b0;
      end else if (en) begin
         side3_ff.valid <= side3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff.func   <= side3_in.func;
         side3_ff.neg    <= side3_in.neg;
         side3_ff.res_x  <= side3_in.res_x;
         side3_ff.res_y  <= side3_in.res_y;
         side3_ff.res_z  <= side3_in.res_z;
         side3_ff.scalar <= side3_in.scalar;
         side3_ff.status <= side3_in.status;
         rad3_ff         <= dot_ff[PROD_W-1:0];
         abs3_ff         <= abs3_in;
      end
   end

   // square root chain
   assign side_c[0] = side3_ff;
   assign rad_c[0]  = rad3_ff;
   assign rem_c[0]  = '0;
   assign root_c[0] = '0;
   assign pass_c[0] = abs3_ff;

   for (genvar k = 0; k < C; k++) begin : g_sqrt
      vau_sqrt_cell #(
         .ROOT_W (C),
         .PASS_W (3 * C)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .side_in  (side_c[k]),
         .rad_in   (rad_c[k]),
         .rem_in   (rem_c[k]),
         .root_in  (root_c[k]),
         .pass_in  (pass_c[k]),
         .side_out (side_c[k+1]),
         .rad_out  (rad_c[k+1]),
         .rem_out  (rem_c[k+1]),
         .root_out (root_c[k+1]),
         .pass_out (pass_c[k+1])
      );
   end

   // divider chain
   assign side_d[0] = side_c[C];
   assign mag_d[0]  = root_c[C];
   assign quo_d[0]  = '0;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         part_d[0][i] = {1'b0, pass_c[C][i*C +: C]};
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      vau_div_cell #(
         .MAG_W (C),
         .Q_W   (Q_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .side_in  (side_d[k]),
         .mag_in   (mag_d[k]),
         .part_in  (part_d[k]),
         .quo_in   (quo_d[k]),
         .side_out (side_d[k+1]),
         .mag_out  (mag_d[k+1]),
         .part_out (part_d[k+1]),
         .quo_out  (quo_d[k+1])
      );
   end

   // fill in magnitude and unit vector, or flag the zero vector
   assign last  = side_d[Q_W];
   assign neg_l = last.neg;
   assign quo_l = quo_d[Q_W];
   assign mag_l = mag_d[Q_W];

   always_comb begin
      out_in = last;
      if (last.func == FUNC_UNIT) begin
         if (mag_l == '0) begin
            out_in.status = STATUS_ZERO_VEC;
         end else begin
            out_in.scalar = {{(OUT_W-C){1'b0}}, mag_l};
            out_in.res_x  = neg_l[0] ? -OUT_W'(quo_l[0]) : OUT_W'(quo_l[0]);
            out_in.res_y  = neg_l[1] ? -OUT_W'(quo_l[1]) : OUT_W'(quo_l[1]);
            out_in.res_z  = neg_l[2] ? -OUT_W'(quo_l[2]) : OUT_W'(quo_l[2]);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.func   <= out_in.func;
         out_ff.neg    <= out_in.neg;
         out_ff.res_x  <= out_in.res_x;
         out_ff.res_y  <= out_in.res_y;
         out_ff.res_z  <= out_in.res_z;
         out_ff.scalar <= out_in.scalar;
         out_ff.status <= out_in.status;
      end
   end

   // park a stalled beat in the skid register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= out_ff.valid & ~rsp_tready;
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_tvalid = skid_valid_ff | out_ff.valid;
   assign rsp_tdata  = skid_valid_ff
      ? RSP_W'({skid_ff.scalar, skid_ff.res_z, skid_ff.res_y, skid_ff.res_x})
      : RSP_W'({out_ff.scalar, out_ff.res_z, out_ff.res_y, out_ff.res_x});
   assign rsp_tuser  = skid_valid_ff ? skid_ff.status : out_ff.status;

endmodule

// ----- sv/vau_checker.sv -----
// Port-level checks for the vector3 arithmetic unit, bound to the top level.
// Depends on vau_pkg and vector3_arithmetic_unit_defines.svh.
`include "vector3_arithmetic_unit_defines.svh"

module vau_checker import vau_pkg::*; #(
   parameter int REQ_W = 192,
   parameter int RSP_W = 200
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [REQ_W-1:0]     req_tdata,
   input logic [FUNC_W-1:0]    req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_W-1:0]     rsp_tdata,
   input logic [STATUS_W-1:0]  rsp_tuser
);

   // a stalled result beat holds
   `VAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   // status is one of the defined codes
   `VAU_ASSERT_SAME(a_status_code, clock, reset, rsp_tvalid, rsp_tuser == STATUS_OK || rsp_tuser == STATUS_ZERO_VEC || rsp_tuser == STATUS_BAD_OP, "undefined status code")

   // a failed operation carries all-zero results
   `VAU_ASSERT_SAME(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata == '0, "nonzero results with error status")

   // input side closes only after a result beat stalled
   `VAU_ASSERT_SAME(a_ready_cause, clock, reset, !req_tready, $past(rsp_tvalid && !rsp_tready), "input stalled without result backpressure")

endmodule

bind vector3_arithmetic_unit vau_checker #(
   .REQ_W (REQ_W),
   .RSP_W (RSP_W)
) u_vau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
